>>> rtl/fpfb_pkg.sv
`timescale 1ns / 1ps

package fpfb_pkg;

	// Default sizes of the packet ring.
	localparam int PacketBytesDef = 32;
	localparam int RingSlotsDef   = 64;

	// Reset values of the header match registers ('U' and 'L').
	localparam logic [7:0] HdrFirstRst  = 8'h55;
	localparam logic [7:0] HdrSecondRst = 8'h4C;

	localparam logic [7:0] DropMax = 8'hFF;

	// Register indexes on the configuration port.
	localparam logic REG_HDR_FIRST  = 1'b0;
	localparam logic REG_HDR_SECOND = 1'b1;

	typedef enum logic [1:0] {
		CMD_BYTE   = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_RD_REQ = 2'd2,
		CMD_POP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_POPPED = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_REPLY  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_POP  = 2'b10
	} state_t;

endpackage

>>> rtl/framed_packet_fifo_bridge.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: command[1:0]; tdata: rx_byte[7:0]
// m_*       out  m_tvalid/m_tready  tuser: status[1:0]; tlast: last;
//                                   tdata: data_byte, byte_index, dropped, short_total
// apb       in   psel/penable       0x0 header_first, 0x4 header_second
//
// Received bytes go straight into the free ring slot, so a finished transfer
// commits by advancing the write pointer. Byte, finish and read requests, and
// a pop on an empty ring, leave the block idle. A pop of a stored packet keeps
// the block busy in S_POP: the packet memory read register is the output
// register, so one byte leaves per cycle while m_tready is high. Reset clears
// pointers and counters and presets the header registers; memory needs no pass.
// A stall on m_tready holds the output and blocks further requests.
module framed_packet_fifo_bridge #(
	parameter int PACKET_BYTES = fpfb_pkg::PacketBytesDef,
	parameter int RING_SLOTS   = fpfb_pkg::RingSlotsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // rx_byte[7:0]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // data_byte[7:0], byte_index[12:8], dropped[20:13],
	                              // short_total[52:21], zero[55:53]
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IdxW  = $clog2(PACKET_BYTES);
	localparam int SlotW = $clog2(RING_SLOTS);
	localparam int FillW = $clog2(PACKET_BYTES + 1);
	localparam int AddrW = SlotW + IdxW;

	fpfb_pkg::state_t  state_q;
	fpfb_pkg::cmd_t    cmd;
	fpfb_pkg::status_t out_status_q;

	logic [7:0]       cfg_first_q, cfg_second_q;
	logic [7:0]       hdr0_q, hdr1_q;
	logic [FillW-1:0] fill_q;
	logic [SlotW-1:0] rd_slot_q, wr_slot_q, rd_slot_next, wr_slot_next;
	logic [IdxW-1:0]  pop_idx_q, out_idx_q;
	logic [7:0]       drop_cnt_q, out_drop_q;
	logic [31:0]      short_cnt_q, out_short_q;
	logic             m_valid_q, out_last_q;

	logic             in_acc, out_free, ring_empty, ring_full, hdr_match;
	logic             pop_start, pop_step, pop_final, cfg_wr, out_load;
	logic             wr_en, rd_en;
	logic [AddrW-1:0] wr_addr, rd_addr;
	logic [7:0]       rd_data, data_byte;

	assign cmd        = fpfb_pkg::cmd_t'(s_tuser);
	assign out_free   = !m_valid_q || m_tready;
	assign s_tready   = (state_q == fpfb_pkg::S_IDLE) && out_free;
	assign in_acc     = s_tvalid && s_tready;
	assign ring_empty = rd_slot_q == wr_slot_q;

	assign rd_slot_next = (rd_slot_q == SlotW'(RING_SLOTS - 1)) ? '0 : rd_slot_q + SlotW'(1);
	assign wr_slot_next = (wr_slot_q == SlotW'(RING_SLOTS - 1)) ? '0 : wr_slot_q + SlotW'(1);
	assign ring_full    = wr_slot_next == rd_slot_q;
	assign hdr_match    = (hdr0_q == cfg_first_q) && (hdr1_q == cfg_second_q);

	assign pop_start = in_acc && (cmd == fpfb_pkg::CMD_POP) && !ring_empty;
	assign pop_step  = (state_q == fpfb_pkg::S_POP) && out_free;
	assign pop_final = pop_step && (pop_idx_q == IdxW'(PACKET_BYTES - 1));
	assign out_load  = (in_acc && ((cmd == fpfb_pkg::CMD_RD_REQ) || (cmd == fpfb_pkg::CMD_POP)))
		|| pop_step;

	// The free slot at the write pointer doubles as the assembly buffer.
	assign wr_en   = in_acc && (cmd == fpfb_pkg::CMD_BYTE) && (fill_q < FillW'(PACKET_BYTES));
	assign wr_addr = {wr_slot_q, fill_q[IdxW-1:0]};
	assign rd_en   = pop_start || pop_step;
	assign rd_addr = {rd_slot_q, pop_start ? IdxW'(0) : pop_idx_q};

	fpfb_pkt_ram #(
		.PACKET_BYTES(PACKET_BYTES),
		.RING_SLOTS  (RING_SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(s_tdata),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = {24'd0, (paddr[2] == fpfb_pkg::REG_HDR_SECOND) ? cfg_second_q : cfg_first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_first_q  <= fpfb_pkg::HdrFirstRst;
			cfg_second_q <= fpfb_pkg::HdrSecondRst;
		end else if (cfg_wr) begin
			if (paddr[2] == fpfb_pkg::REG_HDR_SECOND) begin
				cfg_second_q <= pwdata[7:0];
			end else begin
				cfg_first_q <= pwdata[7:0];
			end
		end
	end

	// The two header bytes are kept beside the memory for the commit check.
	always_ff @(posedge clk) begin
		if (wr_en && (fill_q == FillW'(0))) begin
			hdr0_q <= s_tdata;
		end
		if (wr_en && (fill_q == FillW'(1))) begin
			hdr1_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpfb_pkg::S_IDLE;
			fill_q      <= '0;
			rd_slot_q   <= '0;
			wr_slot_q   <= '0;
			drop_cnt_q  <= '0;
			short_cnt_q <= '0;
			pop_idx_q   <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (in_acc) begin
				unique case (cmd)
					fpfb_pkg::CMD_BYTE: begin
						if (wr_en) begin
							fill_q <= fill_q + FillW'(1);
						end
					end
					fpfb_pkg::CMD_FINISH: begin
						if (fill_q == FillW'(PACKET_BYTES)) begin
							if (hdr_match) begin
								if (!ring_full) begin
									wr_slot_q <= wr_slot_next;
								end else if (drop_cnt_q != fpfb_pkg::DropMax) begin
									drop_cnt_q <= drop_cnt_q + 8'd1;
								end
							end
						end else if (fill_q != '0) begin
							short_cnt_q <= short_cnt_q + 32'd1;
						end
						fill_q <= '0;
					end
					fpfb_pkg::CMD_RD_REQ: ;
					fpfb_pkg::CMD_POP: begin
						if (!ring_empty) begin
							drop_cnt_q <= '0;
							pop_idx_q  <= IdxW'(1);
							state_q    <= fpfb_pkg::S_POP;
						end
					end
					default: ;
				endcase
			end
			if (pop_step) begin
				pop_idx_q <= pop_idx_q + IdxW'(1);
				if (pop_final) begin
					rd_slot_q <= rd_slot_next;
					state_q   <= fpfb_pkg::S_IDLE;
				end
			end
		end
	end

	// Output payload; the data byte itself sits in the memory read register.
	always_ff @(posedge clk) begin
		if (pop_start) begin
			out_status_q <= fpfb_pkg::ST_POPPED;
			out_idx_q    <= '0;
			out_last_q   <= 1'b0;
			out_drop_q   <= drop_cnt_q;
			out_short_q  <= short_cnt_q;
		end else if (in_acc && ((cmd == fpfb_pkg::CMD_RD_REQ) || (cmd == fpfb_pkg::CMD_POP))) begin
			out_status_q <= (cmd == fpfb_pkg::CMD_RD_REQ) ? fpfb_pkg::ST_REPLY : fpfb_pkg::ST_EMPTY;
			out_idx_q    <= '0;
			out_last_q   <= 1'b1;
			out_drop_q   <= '0;
			out_short_q  <= '0;
		end else if (pop_step) begin
			out_idx_q  <= pop_idx_q;
			out_last_q <= pop_final;
		end
	end

	assign data_byte = (out_status_q == fpfb_pkg::ST_POPPED) ? rd_data : 8'h00;
	assign m_tvalid  = m_valid_q;
	assign m_tuser   = out_status_q;
	assign m_tlast   = out_last_q;
	assign m_tdata   = {3'b000, out_short_q, out_drop_q, 5'(out_idx_q), data_byte};

	// A nonempty pop must present a packet byte next.
	a_pop_first: assert property (@(posedge clk) disable iff (!arst_n)
		pop_start |=> m_tvalid && (m_tuser == fpfb_pkg::ST_POPPED) && (m_tdata[12:8] == 5'd0))
		else $error("pop did not present byte zero");

	// The final result of any request is shown only once the block is idle again.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> state_q == fpfb_pkg::S_IDLE)
		else $error("last result shown while a pop is still running");

	// A saturated drop counter stays saturated until a pop clears it.
	a_drop_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(drop_cnt_q == fpfb_pkg::DropMax) && !pop_start |=> drop_cnt_q == fpfb_pkg::DropMax)
		else $error("drop counter left saturation");

	// A committed packet never makes the ring look empty.
	a_commit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (cmd == fpfb_pkg::CMD_FINISH) && (fill_q == FillW'(PACKET_BYTES)) && hdr_match
		|=> rd_slot_q != wr_slot_q)
		else $error("ring empty after a commit");

endmodule

>>> rtl/fpfb_pkt_ram.sv
`timescale 1ns / 1ps

// Packet store: one write port, one read port with registered read data.
// The read register holds its value until the next read is enabled.
module fpfb_pkt_ram #(
	parameter int PACKET_BYTES = fpfb_pkg::PacketBytesDef,
	parameter int RING_SLOTS   = fpfb_pkg::RingSlotsDef,
	localparam int IdxW  = $clog2(PACKET_BYTES),
	localparam int SlotW = $clog2(RING_SLOTS),
	localparam int AddrW = SlotW + IdxW
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [7:0]       wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [7:0]       rd_data
);

	localparam int Depth = RING_SLOTS << IdxW;

	logic [7:0] mem [Depth];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
